>>> hw/rtl/ss_pkg.sv
// Shared types, codes and helpers for the substring search core.
`default_nettype none
package ss_pkg;

    // Request codes on the input word
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_NEEDLE = 2'd1;
    localparam logic [1:0] REQ_HAY    = 2'd2;

    // Depth of the queues between the two halves and at the output
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_CASE_BIT = 8'h20;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic        found;
        logic [15:0] position;
        logic        needle_overflow;
    } out_word_t;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_NEEDLE = 2'd1,
        OP_HAY    = 2'd2
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data_byte;
        logic       last;
    } cmd_t;

    // Engine status seen by the top level
    typedef struct packed {
        logic reported;
        logic needle_empty;
        logic overflow;
    } stat_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
        logic [7:0] r;
        r = b;
        if (en && b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z)
        begin
            r = b | ASCII_CASE_BIT;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ss_fifo.sv
// Small register FIFO used between the front end, the engine and the output.
`default_nettype none
module ss_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  full,
    output logic                  empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/ss_front.sv
// Front end: accepts input words, decodes the request and queues commands.
`default_nettype none
module ss_front (
    input  wire logic             push,
    input  wire ss_pkg::in_word_t in_word,
    input  wire logic             cmd_full,
    output logic                  full,
    output logic                  cmd_push,
    output ss_pkg::cmd_t          cmd_word
);
    logic accept;

    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    always_comb
    begin
        cmd_push           = 1'b0;
        cmd_word.op        = ss_pkg::OP_CLEAR;
        cmd_word.data_byte = in_word.data_byte;
        cmd_word.last      = in_word.last;
        case (in_word.req_type)
            ss_pkg::REQ_CLEAR:
            begin
                cmd_push    = accept;
                cmd_word.op = ss_pkg::OP_CLEAR;
            end
            ss_pkg::REQ_NEEDLE:
            begin
                cmd_push    = accept;
                cmd_word.op = ss_pkg::OP_NEEDLE;
            end
            ss_pkg::REQ_HAY:
            begin
                cmd_push    = accept;
                cmd_word.op = ss_pkg::OP_HAY;
            end
            default:
            begin
                // unused request code: taken and dropped
                cmd_push = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> hw/rtl/ss_back.sv
// Search engine: needle store and shift-and match vector, one command per cycle unless res_full.
`default_nettype none
module ss_back #(
    parameter int NEEDLE_MAX = 32,
    parameter int INDEX_BITS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          case_fold,
    input  wire logic          cmd_valid,
    input  wire ss_pkg::cmd_t  cmd_word,
    output logic               cmd_pop,
    input  wire logic          res_full,
    output logic               res_push,
    output ss_pkg::out_word_t  res_word,
    output ss_pkg::stat_t      stat
);
    localparam int LEN_W = $clog2(NEEDLE_MAX + 1);
    localparam int CMP_W = (INDEX_BITS > LEN_W) ? INDEX_BITS : LEN_W;

    logic [7:0]            needle_reg [NEEDLE_MAX];
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [NEEDLE_MAX-1:0] vec_reg, vec_next, vec_calc;
    logic [INDEX_BITS-1:0] index_reg, index_next;
    logic                  reported_reg, reported_next;
    logic                  ovf_reg, ovf_next;

    logic [7:0]            hay_byte;
    logic                  hit;
    logic                  needle_we;
    logic [CMP_W-1:0]      back_ext, pos_ext;
    logic [INDEX_BITS-1:0] start;

    assign cmd_pop  = cmd_valid && !res_full;
    assign hay_byte = ss_pkg::fold_byte(cmd_word.data_byte, case_fold);

    assign needle_we = cmd_pop && (cmd_word.op == ss_pkg::OP_NEEDLE)
                       && (index_reg == '0) && !reported_reg
                       && (len_reg < LEN_W'(NEEDLE_MAX));

    // all needle positions compared in parallel
    always_comb
    begin
        hit = 1'b0;
        for (int i = 0; i < NEEDLE_MAX; i++)
        begin
            vec_calc[i] = (LEN_W'(i) < len_reg)
                          && ((i == 0) ? 1'b1 : vec_reg[(i == 0) ? 0 : i - 1])
                          && (ss_pkg::fold_byte(needle_reg[i], case_fold) == hay_byte);
            if (LEN_W'(i + 1) == len_reg)
            begin
                hit = vec_calc[i];
            end
        end
    end

    // match start = index - (len - 1), floored at zero
    assign back_ext = CMP_W'(len_reg - 1'b1);
    assign pos_ext  = CMP_W'(index_reg);
    assign start    = (pos_ext >= back_ext) ? INDEX_BITS'(pos_ext - back_ext) : '0;

    always_comb
    begin
        len_next      = len_reg;
        vec_next      = vec_reg;
        index_next    = index_reg;
        reported_next = reported_reg;
        ovf_next      = ovf_reg;
        res_push      = 1'b0;
        res_word      = '0;
        if (cmd_pop)
        begin
            case (cmd_word.op)
                ss_pkg::OP_CLEAR:
                begin
                    len_next      = '0;
                    vec_next      = '0;
                    index_next    = '0;
                    reported_next = 1'b0;
                    ovf_next      = 1'b0;
                end
                ss_pkg::OP_NEEDLE:
                begin
                    if (index_reg == '0 && !reported_reg)
                    begin
                        if (len_reg < LEN_W'(NEEDLE_MAX))
                        begin
                            len_next = len_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                end
                ss_pkg::OP_HAY:
                begin
                    if (!reported_reg)
                    begin
                        index_next = (index_reg == '1) ? index_reg : index_reg + 1'b1;
                        if (len_reg == '0)
                        begin
                            res_push                 = 1'b1;
                            res_word.found           = 1'b1;
                            res_word.position        = 16'(index_reg);
                            res_word.needle_overflow = ovf_reg;
                            reported_next            = 1'b1;
                        end
                        else
                        begin
                            vec_next = vec_calc;
                            if (hit)
                            begin
                                res_push                 = 1'b1;
                                res_word.found           = 1'b1;
                                res_word.position        = 16'(start);
                                res_word.needle_overflow = ovf_reg;
                                reported_next            = 1'b1;
                            end
                            else if (cmd_word.last)
                            begin
                                res_push                 = 1'b1;
                                res_word.found           = 1'b0;
                                res_word.position        = '0;
                                res_word.needle_overflow = ovf_reg;
                                reported_next            = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            vec_reg      <= '0;
            index_reg    <= '0;
            reported_reg <= 1'b0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            len_reg      <= len_next;
            vec_reg      <= vec_next;
            index_reg    <= index_next;
            reported_reg <= reported_next;
            ovf_reg      <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NEEDLE_MAX; i++)
        begin
            if (needle_we && (len_reg == LEN_W'(i)))
            begin
                needle_reg[i] <= cmd_word.data_byte;
            end
        end
    end

    assign stat.reported     = reported_reg;
    assign stat.needle_empty = (len_reg == '0);
    assign stat.overflow     = ovf_reg;

endmodule
`default_nettype wire

>>> hw/rtl/substring_search_core.sv
// Top level of the streaming substring search core.
// Usage:
//   Input side looks like a queue: drive in_word and push; the word is taken
//   at a rising edge with push high and full low. req_type selects clear
//   (start a new search), needle byte append, or haystack byte (last marks
//   the final haystack byte). Unused request codes are taken and dropped.
//   Output side looks like a queue: while empty is low the oldest result is
//   on out_word; it is taken at a rising edge with pop high and empty low.
//   At most one result per search: at the first match (found, start position) or at
//   the last haystack byte with no match.
//   cfg_wr_en/cfg_wr_data write case_fold; write it only while idle.
// Timing:
//   Front end decodes into a two-word command queue; while the result queue
//   is not full the engine takes one command per cycle, comparing every
//   needle position in parallel, so throughput is one word per cycle. The
//   result is pushed as its command is popped; empty drops as it is stored.
// Reset: rst_n clears both queues, the search state and case_fold.
// Stalls:
//   When the result queue is full the engine holds; the command queue then
//   fills and full rises. Nothing is lost.
`default_nettype none
module substring_search_core #(
    parameter int NEEDLE_MAX = 32,
    parameter int INDEX_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire ss_pkg::in_word_t  in_word,
    output logic                   empty,
    input  wire logic              pop,
    output ss_pkg::out_word_t      out_word,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_wr_data
);
    localparam int CMD_W = $bits(ss_pkg::cmd_t);
    localparam int RES_W = $bits(ss_pkg::out_word_t);

    logic              case_fold_reg;
    logic              cmd_push, cmd_full, cmd_empty, cmd_pop;
    ss_pkg::cmd_t      cmd_in, cmd_out;
    logic [CMD_W-1:0]  cmd_rd_bits;
    logic              res_push, res_full;
    ss_pkg::out_word_t res_word;
    logic [RES_W-1:0]  res_rd_bits;
    ss_pkg::stat_t     stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            case_fold_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case_fold_reg <= cfg_wr_data;
        end
    end

    ss_front u_front (
        .push     (push),
        .in_word  (in_word),
        .cmd_full (cmd_full),
        .full     (full),
        .cmd_push (cmd_push),
        .cmd_word (cmd_in)
    );

    ss_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (ss_pkg::QUEUE_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .rd_en   (cmd_pop),
        .rd_data (cmd_rd_bits),
        .full    (cmd_full),
        .empty   (cmd_empty)
    );

    assign cmd_out = ss_pkg::cmd_t'(cmd_rd_bits);

    ss_back #(
        .NEEDLE_MAX (NEEDLE_MAX),
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .case_fold (case_fold_reg),
        .cmd_valid (!cmd_empty),
        .cmd_word  (cmd_out),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_word  (res_word),
        .stat      (stat)
    );

    ss_fifo #(
        .WIDTH (RES_W),
        .DEPTH (ss_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_word),
        .rd_en   (pop),
        .rd_data (res_rd_bits),
        .full    (res_full),
        .empty   (empty)
    );

    assign out_word = ss_pkg::out_word_t'(res_rd_bits);

`ifndef SYNTHESIS
    // a clear leaves an empty, unflagged, unreported search
    a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && cmd_out.op == ss_pkg::OP_CLEAR)
        |=> (stat.needle_empty && !stat.reported && !stat.overflow))
        else $error("clear did not reset search state");

    // every result marks the search as reported
    a_result_reports: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> stat.reported)
        else $error("result without reported flag");

    // at most one result per search
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        stat.reported |-> !res_push)
        else $error("second result in one search");

    // unused request codes never reach the engine
    a_drop_unused: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && in_word.req_type != ss_pkg::REQ_CLEAR
         && in_word.req_type != ss_pkg::REQ_NEEDLE
         && in_word.req_type != ss_pkg::REQ_HAY) |-> !cmd_push)
        else $error("unused request queued");
`endif

endmodule
`default_nettype wire

>>> dv/tb_substring_search_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the streaming substring search core.
module tb_substring_search_core;

    // Sizes match the core's defaults; the predictor is built for them.
    localparam int NEEDLE_MAX = 32;
    localparam int INDEX_BITS = 16;
    localparam int INDEX_MAX  = (1 << INDEX_BITS) - 1;

    // The one request code the package leaves unnamed; the core drops it.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Results pass through both core queues after their word is taken; leave margin.
    localparam int SETTLE_CYCLES = 8;
    // Watchdog limit on the whole run, with a wide margin even with every
    // gap and stall at its longest.
    localparam int CYCLE_LIMIT   = 1_000_000;
    // Receiver hold-off for the backpressure test, long enough to fill
    // both internal queues many times over.
    localparam int LONG_HOLD     = 400;

    // Byte values near the case-fold boundaries.
    localparam logic [7:0] CH_AT    = 8'h40;  // one below 'A'
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_B  = 8'h42;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LBRK  = 8'h5B;  // one above 'Z'
    localparam logic [7:0] CH_TICK  = 8'h60;  // '@' with the case bit set
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_LO_C  = 8'h63;
    localparam logic [7:0] CH_LO_Q  = 8'h71;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_LBRC  = 8'h7B;  // '[' with the case bit set

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    ss_pkg::in_word_t  in_word;
    logic              empty;
    logic              pop;
    ss_pkg::out_word_t out_word;
    logic              cfg_wr_en;
    logic              cfg_wr_data;

    substring_search_core #(
        .NEEDLE_MAX (NEEDLE_MAX),
        .INDEX_BITS (INDEX_BITS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_word     (in_word),
        .empty       (empty),
        .pop         (pop),
        .out_word    (out_word),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Search predictor state (mirror of the core after reset)
    // ------------------------------------------------------------------
    logic [7:0]            needle_mem [NEEDLE_MAX];
    int                    needle_len     = 0;
    logic [NEEDLE_MAX-1:0] match_vec      = '0;   // bit i: last i+1 bytes match
    int                    hay_index      = 0;
    bit                    search_done    = 1'b0;
    bit                    needle_dropped = 1'b0;
    bit                    fold_en        = 1'b0;

    // Expected result words, oldest first
    ss_pkg::out_word_t pending_results[$];

    int mismatch_count = 0;
    int words_sent     = 0;   // words the core acts on (unused codes not counted)
    int cycle_count    = 0;
    bit idle_on        = 1'b1;
    int hold_request   = 0;   // picked up by the pop driver

    function automatic logic [7:0] fold_char(input logic [7:0] b);
        if (fold_en && b >= ss_pkg::ASCII_UPPER_A && b <= ss_pkg::ASCII_UPPER_Z)
        begin
            return b | ss_pkg::ASCII_CASE_BIT;
        end
        return b;
    endfunction

    function automatic void post_result(input bit hit, input int pos);
        ss_pkg::out_word_t r;
        r.found           = hit;
        r.position        = hit ? 16'(pos) : 16'd0;
        r.needle_overflow = needle_dropped;
        pending_results.push_back(r);
        search_done = 1'b1;
    endfunction

    // Apply one accepted word to the predictor; queue a result if it makes one.
    function automatic void predict_search(input ss_pkg::in_word_t w);
        int         pos;
        logic [7:0] h;
        bit         prev;
        case (w.req_type)
            ss_pkg::REQ_CLEAR:
            begin
                match_vec      = '0;
                needle_len     = 0;
                hay_index      = 0;
                search_done    = 1'b0;
                needle_dropped = 1'b0;
            end
            ss_pkg::REQ_NEEDLE:
            begin
                // needle is frozen once the haystack has started
                if (hay_index == 0 && !search_done)
                begin
                    if (needle_len < NEEDLE_MAX)
                    begin
                        needle_mem[needle_len] = w.data_byte;
                        needle_len++;
                    end
                    else
                    begin
                        needle_dropped = 1'b1;
                    end
                end
            end
            ss_pkg::REQ_HAY:
            begin
                if (!search_done)
                begin
                    pos = hay_index;
                    if (hay_index < INDEX_MAX)
                    begin
                        hay_index++;
                    end
                    if (needle_len == 0)
                    begin
                        post_result(1'b1, pos);
                    end
                    else
                    begin
                        h = fold_char(w.data_byte);
                        // top-down so each bit sees the previous cycle's neighbor
                        for (int i = needle_len - 1; i >= 0; i--)
                        begin
                            prev = (i == 0) ? 1'b1 : match_vec[i-1];
                            match_vec[i] = prev && (fold_char(needle_mem[i]) == h);
                        end
                        if (match_vec[needle_len-1])
                        begin
                            post_result(1'b1, (pos >= needle_len - 1) ?
                                        pos - (needle_len - 1) : 0);
                        end
                        else if (w.last)
                        begin
                            post_result(1'b0, 0);
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatch_count++;
        // keep the log short when something is badly broken
        if (mismatch_count <= 100)
        begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    task automatic check_result(input ss_pkg::out_word_t got);
        ss_pkg::out_word_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word found=%0b position=%0d overflow=%0b",
                                      got.found, got.position, got.needle_overflow));
            return;
        end
        want = pending_results.pop_front();
        if (got.found !== want.found)
        begin
            report_mismatch($sformatf("found %0b, want %0b", got.found, want.found));
        end
        if (got.position !== want.position)
        begin
            report_mismatch($sformatf("position %0d, want %0d", got.position, want.position));
        end
        if (got.needle_overflow !== want.needle_overflow)
        begin
            report_mismatch($sformatf("needle_overflow %0b, want %0b",
                                      got.needle_overflow, want.needle_overflow));
        end
    endtask

    // Everything changes at the rising edge, so the negedge sees the values
    // that the next rising edge will act on.
    always @(negedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            check_result(out_word);
        end
    end

    // Pop driver: random stall bursts, plus a long hold-off on request.
    initial
    begin : pop_driver
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 9) - 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_substring_search_core: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one word; returns at the rising edge that took it. push stays
    // high so back-to-back words go out without a bubble.
    task automatic send_req(input logic [1:0] req, input logic [7:0] data,
                            input logic last_flag);
        ss_pkg::in_word_t w;
        int               gap;
        bit               taken;
        w.req_type  = req;
        w.data_byte = data;
        w.last      = last_flag;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 9);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        in_word <= w;
        do
        begin
            @(negedge clk);
            taken = !full;
            @(posedge clk);
        end
        while (!taken);
        predict_search(w);
        if (req != REQ_UNUSED)
        begin
            words_sent++;
        end
    endtask

    // Stop offering and wait until every expected word is out, then let
    // words that make no result finish inside the core.
    task automatic drain_results();
        push <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // case_fold is only written with the core idle.
    task automatic set_case_fold(input bit v);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        fold_en = v;
    endtask

    // Mostly a tiny alphabet so matches are common, with case-boundary
    // bytes and the full byte range mixed in.
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
        begin
            case ($urandom_range(0, 3))
                0: return CH_LO_A;
                1: return CH_UP_A;
                2: return CH_LO_B;
                default: return CH_UP_B;
            endcase
        end
        else if (r < 8)
        begin
            case ($urandom_range(0, 5))
                0: return CH_AT;
                1: return CH_LBRK;
                2: return CH_TICK;
                3: return CH_LBRC;
                4: return CH_UP_Z;
                default: return CH_LO_Z;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] swap_case(input logic [7:0] b);
        if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A))
        begin
            return b ^ ss_pkg::ASCII_CASE_BIT;
        end
        return b;
    endfunction

    // One search: clear (mostly), needle, haystack (mostly ending in last), with some noise.
    task automatic random_search();
        logic [7:0] needle_bytes[$];
        logic [7:0] hay_bytes[$];
        int         nlen;
        int         hlen;
        int         keep;
        int         at;
        int         r;
        logic       end_flag;
        // now and then skip the clear and run on whatever state is left
        if ($urandom_range(0, 19) != 0)
        begin
            send_req(ss_pkg::REQ_CLEAR, 8'($urandom), 1'($urandom));
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            nlen = 0;
        end
        else if (r < 10)
        begin
            nlen = $urandom_range(NEEDLE_MAX - 4, NEEDLE_MAX + 4);  // around full
        end
        else if (r < 25)
        begin
            nlen = $urandom_range(6, 12);
        end
        else
        begin
            nlen = $urandom_range(1, 5);
        end
        for (int i = 0; i < nlen; i++)
        begin
            needle_bytes.push_back(pick_byte());
            send_req(ss_pkg::REQ_NEEDLE, needle_bytes[i], 1'($urandom));
        end

        hlen = ($urandom_range(0, 39) == 0) ? 0 : $urandom_range(1, 40);
        for (int i = 0; i < hlen; i++)
        begin
            hay_bytes.push_back(pick_byte());
        end
        // plant the stored part of the needle, sometimes with case flipped
        keep = (nlen > NEEDLE_MAX) ? NEEDLE_MAX : nlen;
        if (keep > 0 && keep <= hlen && $urandom_range(0, 1) == 1)
        begin
            at = $urandom_range(0, hlen - keep);
            for (int i = 0; i < keep; i++)
            begin
                hay_bytes[at+i] = ($urandom_range(0, 3) == 0) ?
                                  swap_case(needle_bytes[i]) : needle_bytes[i];
            end
        end

        for (int i = 0; i < hlen; i++)
        begin
            if ($urandom_range(0, 29) == 0)
            begin
                send_req(REQ_UNUSED, 8'($urandom), 1'($urandom));
            end
            if ($urandom_range(0, 39) == 0)
            begin
                send_req(ss_pkg::REQ_NEEDLE, pick_byte(), 1'b0);   // late needle byte
            end
            if (i == hlen - 1)
            begin
                end_flag = ($urandom_range(0, 14) != 0);   // sometimes abandoned
            end
            else
            begin
                end_flag = ($urandom_range(0, 49) == 0);   // early end
            end
            send_req(ss_pkg::REQ_HAY, hay_bytes[i], end_flag);
        end
        // stray bytes after the search is over
        if ($urandom_range(0, 9) == 0)
        begin
            send_req(ss_pkg::REQ_HAY, pick_byte(), 1'($urandom));
            send_req(ss_pkg::REQ_NEEDLE, pick_byte(), 1'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty needle hits at index 0; later bytes are ignored; an empty
    // haystack gives nothing.
    task automatic test_empty_needle();
        send_req(ss_pkg::REQ_CLEAR, 8'hFF, 1'b1);
        send_req(ss_pkg::REQ_HAY, CH_LO_X, 1'b0);
        send_req(ss_pkg::REQ_HAY, CH_LO_X, 1'b1);        // search already done
        send_req(ss_pkg::REQ_CLEAR, 8'h00, 1'b0);
        send_req(ss_pkg::REQ_HAY, CH_LO_Q, 1'b1);
        send_req(ss_pkg::REQ_CLEAR, 8'h00, 1'b0);
        send_req(ss_pkg::REQ_NEEDLE, CH_LO_A, 1'b0);
        send_req(ss_pkg::REQ_CLEAR, 8'h00, 1'b0);        // no haystack at all
    endtask

    // Exact compare: plain hit, case mismatch, zero bytes, needle too long.
    task automatic test_exact_match();
        set_case_fold(1'b0);
        send_req(ss_pkg::REQ_CLEAR, 8'h00, 1'b0);
        send_req(ss_pkg::REQ_NEEDLE, CH_LO_A, 1'b0);
        send_req(ss_pkg::REQ_NEEDLE, CH_UP_B, 1'b0);
        send_req(ss_pkg::REQ_HAY, CH_LO_X, 1'b0);
        send_req(ss_pkg::REQ_HAY, CH_LO_A, 1'b0);
        send_req(ss_pkg::REQ_HAY, CH_UP_B, 1'b0);        // hit at 1
        send_req(ss_pkg::REQ_HAY, CH_LO_Z, 1'b1);
        send_req(ss_pkg::REQ_CLEAR, 8'h00, 1'b0);
        send_req(ss_pkg::REQ_NEEDLE, CH_LO_A, 1'b0);
        send_req(ss_pkg::REQ_NEEDLE, CH_UP_B, 1'b0);
        send_req(ss_pkg::REQ_HAY, CH_UP_A, 1'b0);
        send_req(ss_pkg::REQ_HAY, CH_LO_B, 1'b1);        // case differs: miss
        send_req(ss_pkg::REQ_CLEAR, 8'h00, 1'b0);
        send_req(ss_pkg::REQ_NEEDLE, 8'h00, 1'b0);       // zero is an ordinary byte
        send_req(ss_pkg::REQ_NEEDLE, 8'hFF, 1'b0);
        send_req(ss_pkg::REQ_HAY, 8'h00, 1'b0);
        send_req(ss_pkg::REQ_HAY, 8'h00, 1'b0);
        send_req(ss_pkg::REQ_HAY, 8'hFF, 1'b1);
        send_req(ss_pkg::REQ_CLEAR, 8'h00, 1'b0);
        send_req(ss_pkg::REQ_NEEDLE, CH_LO_A, 1'b0);
        send_req(ss_pkg::REQ_NEEDLE, CH_LO_B, 1'b0);
        send_req(ss_pkg::REQ_NEEDLE, CH_LO_C, 1'b0);
        send_req(ss_pkg::REQ_HAY, CH_LO_A, 1'b0);
        send_req(ss_pkg::REQ_HAY, CH_LO_B, 1'b1);        // needle longer than haystack
    endtask

    // Folding touches letters only; bytes next to the letter ranges stay apart.
    task automatic test_case_fold();
        set_case_fold(1'b1);
        send_req(ss_pkg::REQ_CLEAR, 8'h00, 1'b0);
        send_req(ss_pkg::REQ_NEEDLE, CH_UP_A, 1'b0);
        send_req(ss_pkg::REQ_NEEDLE, CH_LO_B, 1'b0);
        send_req(ss_pkg::REQ_HAY, CH_LO_Z, 1'b0);
        send_req(ss_pkg::REQ_HAY, CH_LO_A, 1'b0);
        send_req(ss_pkg::REQ_HAY, CH_UP_B, 1'b1);
        send_req(ss_pkg::REQ_CLEAR, 8'h00, 1'b0);
        send_req(ss_pkg::REQ_NEEDLE, CH_LBRK, 1'b0);
        send_req(ss_pkg::REQ_HAY, CH_LBRC, 1'b0);
        send_req(ss_pkg::REQ_HAY, CH_AT, 1'b0);
        send_req(ss_pkg::REQ_HAY, CH_TICK, 1'b1);
        send_req(ss_pkg::REQ_CLEAR, 8'h00, 1'b0);
        send_req(ss_pkg::REQ_NEEDLE, CH_UP_Z, 1'b0);
        send_req(ss_pkg::REQ_NEEDLE, CH_UP_A, 1'b0);
        send_req(ss_pkg::REQ_HAY, CH_LO_Z, 1'b0);
        send_req(ss_pkg::REQ_HAY, CH_LO_A, 1'b0);
    endtask

    // Full needle store, dropped bytes, late needle bytes, unused code.
    task automatic test_needle_overflow();
        set_case_fold(1'b0);
        send_req(ss_pkg::REQ_CLEAR, 8'h00, 1'b0);
        for (int i = 0; i < NEEDLE_MAX; i++)
        begin
            send_req(ss_pkg::REQ_NEEDLE, CH_LO_A, 1'b0);
        end
        send_req(ss_pkg::REQ_NEEDLE, CH_LO_B, 1'b0);     // dropped, flag set
        send_req(ss_pkg::REQ_NEEDLE, CH_LO_C, 1'b1);
        send_req(REQ_UNUSED, 8'hFF, 1'b1);
        for (int i = 0; i < NEEDLE_MAX - 1; i++)
        begin
            send_req(ss_pkg::REQ_HAY, CH_LO_A, 1'b0);
            if (i == 3)
            begin
                send_req(ss_pkg::REQ_NEEDLE, CH_LO_Q, 1'b0);   // after haystack: ignored
            end
        end
        send_req(ss_pkg::REQ_HAY, CH_LO_A, 1'b0);        // hit at 0 with overflow
        send_req(ss_pkg::REQ_HAY, CH_LO_A, 1'b1);
    endtask

    // Receiver holds off while short searches keep coming, so the core's
    // queues fill and full must throttle the sender.
    task automatic test_backpressure();
        drain_results();
        idle_on      = 1'b0;
        hold_request = LONG_HOLD;
        @(posedge clk);
        for (int k = 0; k < 30; k++)
        begin
            send_req(ss_pkg::REQ_CLEAR, 8'h00, 1'b0);
            send_req(ss_pkg::REQ_HAY, 8'(k), 1'b1);
        end
        drain_results();
        idle_on = 1'b1;
    endtask

    task automatic test_random_searches(input bit fold, input int target, input bit idle);
        int start;
        set_case_fold(fold);
        idle_on = idle;
        start   = words_sent;
        while (words_sent - start < target)
        begin
            random_search();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n       <= 1'b0;
        push        <= 1'b0;
        in_word     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_needle();
        test_exact_match();
        test_case_fold();
        test_needle_overflow();
        test_backpressure();
        test_random_searches(1'b0, 400, 1'b1);
        test_random_searches(1'b1, 400, 1'b1);
        test_random_searches(1'b0, 350, 1'b1);
        // closing stretch runs flat out on both sides
        test_random_searches(1'b1, 350, 1'b0);

        drain_results();
        if (mismatch_count == 0)
        begin
            $display("tb_substring_search_core: PASS");
        end
        else
        begin
            $display("tb_substring_search_core: FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/ss_pkg.sv
hw/rtl/ss_fifo.sv
hw/rtl/ss_front.sv
hw/rtl/ss_back.sv
hw/rtl/substring_search_core.sv
dv/tb_substring_search_core.sv
